FILE: hw/rtl/ddo_pkg.sv
// Shared types, constants and tables for the differential-drive odometry core.
// Depends on nothing; the controller, datapath and top-level core import it.
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int MUL_BITS         = 32;
    localparam int DIV_BITS         = 64;

    localparam logic [23:0] MPT_RESET    = 24'd34105;
    localparam logic [23:0] IWB_RESET    = 24'd436907;
    localparam logic [31:0] MAXDT_RESET  = 32'd1000000000;

    localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
    localparam logic [31:0] CORDIC_GAIN_Q23 = 32'd5094007;
    localparam logic [31:0] US_PER_S        = 32'd1000000;
    localparam int          MOVE_MIN_Q24    = 168;
    localparam int          TURN_MIN_Q32    = 42950;

    localparam logic [1:0] CFG_METERS_PER_TICK = 2'd0;
    localparam logic [1:0] CFG_INV_WHEEL_BASE  = 2'd1;
    localparam logic [1:0] CFG_MAX_INTERVAL    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_L, ST_MUL_R, ST_MUL_TH, ST_MUL_STEP, ST_MUL_GAIN,
        ST_CORDIC, ST_MUL_V, ST_DIV_V, ST_MUL_W, ST_DIV_W, ST_COMMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_MUL_L, OP_MUL_R, OP_MUL_TH, OP_MUL_STEP, OP_MUL_GAIN,
        OP_CORDIC, OP_MUL_V, OP_DIV_V, OP_MUL_W, OP_DIV_W
    } t_op;

    typedef struct packed {
        logic accept;
        logic start;
        t_op  op;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_status;

    function automatic logic [31:0] cordic_atan(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/ddo_if.sv
// Valid/ready channel interfaces for update requests and pose results.
// Depends on nothing.
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic        [31:0] elapsed_us;
    modport source (output valid, left_count, right_count, elapsed_us, input ready);
    modport sink   (input valid, left_count, right_count, elapsed_us, output ready);
endinterface

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic        [31:0] heading;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;
    modport source (output valid, position_x, position_y, heading, linear_velocity,
                    angular_velocity, input ready);
    modport sink   (input valid, position_x, position_y, heading, linear_velocity,
                    angular_velocity, output ready);
endinterface

FILE: hw/rtl/ddo_controller.sv
// Sequencing state machine: walks each update through the datapath steps.
// Depends on ddo_pkg.
module ddo_controller import ddo_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_first, n_first;
    logic   r_out_valid, n_out_valid;

    function automatic t_op op_of(input t_state s);
        t_op r;
        unique case (s)
            ST_MUL_L:    r = OP_MUL_L;
            ST_MUL_R:    r = OP_MUL_R;
            ST_MUL_TH:   r = OP_MUL_TH;
            ST_MUL_STEP: r = OP_MUL_STEP;
            ST_MUL_GAIN: r = OP_MUL_GAIN;
            ST_CORDIC:   r = OP_CORDIC;
            ST_MUL_V:    r = OP_MUL_V;
            ST_DIV_V:    r = OP_DIV_V;
            ST_MUL_W:    r = OP_MUL_W;
            ST_DIV_W:    r = OP_DIV_W;
            default:     r = OP_NONE;
        endcase
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_first      = r_first;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (r_first) begin
                        // first request only latches the counts
                        n_first = 1'b0;
                    end else begin
                        n_state     = ST_MUL_L;
                        o_cmd.start = 1'b1;
                    end
                end
            end
            ST_MUL_L:    if (i_status.done) begin n_state = ST_MUL_R;    o_cmd.start = 1'b1; end
            ST_MUL_R:    if (i_status.done) begin n_state = ST_MUL_TH;   o_cmd.start = 1'b1; end
            ST_MUL_TH:   if (i_status.done) begin n_state = ST_MUL_STEP; o_cmd.start = 1'b1; end
            ST_MUL_STEP: if (i_status.done) begin n_state = ST_MUL_GAIN; o_cmd.start = 1'b1; end
            ST_MUL_GAIN: if (i_status.done) begin n_state = ST_CORDIC;   o_cmd.start = 1'b1; end
            ST_CORDIC:   if (i_status.done) begin n_state = ST_MUL_V;    o_cmd.start = 1'b1; end
            ST_MUL_V:    if (i_status.done) begin n_state = ST_DIV_V;    o_cmd.start = 1'b1; end
            ST_DIV_V:    if (i_status.done) begin n_state = ST_MUL_W;    o_cmd.start = 1'b1; end
            ST_MUL_W:    if (i_status.done) begin n_state = ST_DIV_W;    o_cmd.start = 1'b1; end
            ST_DIV_W:    if (i_status.done) begin n_state = ST_COMMIT; end
            ST_COMMIT: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.op    = op_of(n_state);
        n_out_valid = o_cmd.commit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/ddo_datapath.sv
// Odometry datapath: config registers, pose state, shared shift-add multiplier,
// CORDIC rotator, restoring divider and result register. Depends on ddo_pkg.
module ddo_datapath import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [15:0] i_left_count,
    input  logic signed [15:0] i_right_count,
    input  logic [31:0]        i_elapsed_us,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    output logic signed [31:0] o_position_x,
    output logic signed [31:0] o_position_y,
    output logic [31:0]        o_heading,
    output logic signed [31:0] o_linear_velocity,
    output logic signed [31:0] o_angular_velocity
);

    localparam int XW = 48;

    logic [23:0] r_mpt, r_iwb;
    logic [31:0] r_maxdt;
    logic signed [15:0] r_prev_l, r_prev_r;
    logic signed [31:0] r_pose_x, r_pose_y;
    logic [31:0] r_pose_h;

    logic signed [16:0] r_dl, r_dr;
    logic [31:0]        r_dt;
    logic signed [40:0] r_wl, r_wr;
    logic signed [57:0] r_th;
    logic [31:0]        r_step;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic [31:0]        r_v, r_w;

    logic signed [63:0] r_ma, r_acc;
    logic [31:0]        r_mb;
    logic [32:0]        r_rem;
    logic [63:0]        r_quo;
    logic               r_neg, r_nz;
    logic [6:0]         r_cnt;
    logic               r_run, r_load;
    t_op                r_op;

    logic [31:0] r_o_x, r_o_y, r_o_h, r_o_v, r_o_w;

    // derived quantities
    logic signed [41:0] d_sum, th_diff;
    logic signed [40:0] d;
    logic signed [33:0] thr;
    logic signed [32:0] rd8;
    logic signed [41:0] rth16;
    logic signed [41:0] th_diff_r;
    logic signed [57:0] th_r;
    logic signed [40:0] d_r;

    assign d_sum     = {r_wl[40], r_wl} + {r_wr[40], r_wr};
    assign d         = d_sum[41:1];
    assign th_diff   = {r_wr[40], r_wr} - {r_wl[40], r_wl};
    assign th_diff_r = th_diff + 42'sd128;
    assign thr       = th_diff_r[41:8];
    assign d_r       = d + 41'sd128;
    assign rd8       = d_r[40:8];
    assign th_r      = r_th + 58'sd32768;
    assign rth16     = th_r[57:16];

    // shared units, one step each
    logic signed [63:0] m_acc_nx;
    logic [32:0]        q_rem2, q_rem_nx;
    logic               q_ge;
    logic [63:0]        q_quo_nx;
    logic [4:0]         c_sh;
    logic signed [XW-1:0] c_xs, c_ys;
    logic signed [33:0] c_atan;

    assign m_acc_nx = r_acc + (r_mb[0] ? r_ma : 64'sd0);
    assign q_rem2   = {r_rem[31:0], r_quo[63]};
    assign q_ge     = q_rem2 >= {1'b0, r_dt};
    assign q_rem_nx = q_ge ? q_rem2 - {1'b0, r_dt} : q_rem2;
    assign q_quo_nx = {r_quo[62:0], q_ge};
    assign c_sh     = r_cnt[4:0];
    assign c_xs     = r_x >>> c_sh;
    assign c_ys     = r_y >>> c_sh;
    assign c_atan   = {2'b00, cordic_atan(c_sh)};

    logic [6:0] limit;
    logic       last;
    always_comb begin
        case (r_op)
            OP_CORDIC:           limit = 7'(CORDIC_STEPS);
            OP_DIV_V, OP_DIV_W:  limit = 7'(DIV_BITS);
            default:             limit = 7'(MUL_BITS);
        endcase
    end
    assign last            = r_run && (r_cnt == limit - 7'd1);
    assign o_status.done   = last;

    // load-cycle operands
    logic signed [63:0] ld_a;
    logic [31:0]        ld_b;
    always_comb begin
        ld_a = 64'sd0;
        ld_b = 32'd0;
        case (r_op)
            OP_MUL_L:    begin ld_a = 64'(r_dl);  ld_b = {8'd0, r_mpt}; end
            OP_MUL_R:    begin ld_a = 64'(r_dr);  ld_b = {8'd0, r_mpt}; end
            OP_MUL_TH:   begin ld_a = 64'(thr);   ld_b = {8'd0, r_iwb}; end
            OP_MUL_STEP: begin ld_a = 64'(r_th);  ld_b = INV_TWO_PI_Q32; end
            OP_MUL_GAIN: begin ld_a = 64'(d);     ld_b = CORDIC_GAIN_Q23; end
            OP_MUL_V:    begin ld_a = 64'(rd8);   ld_b = US_PER_S; end
            OP_MUL_W:    begin ld_a = 64'(rth16); ld_b = US_PER_S; end
            default:     begin ld_a = 64'sd0;     ld_b = 32'd0; end
        endcase
    end

    // divider dividend: |num| + dt/2
    logic        dv_neg;
    logic [63:0] dv_mag;
    assign dv_neg = r_acc[63];
    assign dv_mag = (dv_neg ? 64'(-r_acc) : 64'(r_acc)) + {33'd0, r_dt[31:1]};

    // CORDIC setup from the gain product
    logic [63:0]        g_round;
    logic signed [40:0] x0;
    logic [31:0]        ang, ang_f;
    logic               fold;
    logic [63:0]        step_round;
    assign g_round    = m_acc_nx + 64'sd4194304;
    assign x0         = g_round[63:23];
    assign ang        = r_pose_h - r_step;
    assign fold       = (ang >= 32'h4000_0000) && (ang < 32'hC000_0000);
    assign ang_f      = fold ? ang - 32'h8000_0000 : ang;
    assign step_round = m_acc_nx + 64'h0000_0000_8000_0000;

    function automatic logic [31:0] rate_res(input logic neg, input logic nz,
                                             input logic dt0, input logic [63:0] q);
        logic [32:0] qc;
        logic [32:0] qn;
        logic [31:0] r;
        qc = (q > 64'h0000_0000_8000_0000) ? 33'h0_8000_0000 : q[32:0];
        qn = -qc;
        if (dt0) begin
            r = !nz ? 32'd0 : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
        end else if (neg) begin
            r = qn[31:0];
        end else begin
            r = qc[31] ? 32'h7FFF_FFFF : qc[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat41(input logic signed [40:0] v);
        logic [31:0] r;
        if (v > 41'sh0_7FFF_FFFF)       r = 32'h7FFF_FFFF;
        else if (v < -41'sh0_8000_0000) r = 32'h8000_0000;
        else                            r = v[31:0];
        return r;
    endfunction

    // commit values
    logic signed [XW-1:0] x_r, y_r;
    logic signed [39:0]   dxr, dyr;
    logic signed [40:0]   px_sum, py_sum;
    logic                 moved, turned;
    assign x_r    = r_x + XW'(128);
    assign y_r    = r_y + XW'(128);
    assign dxr    = x_r[XW-1:8];
    assign dyr    = y_r[XW-1:8];
    assign px_sum = 41'(r_pose_x) + 41'(dxr);
    assign py_sum = 41'(r_pose_y) + 41'(dyr);
    assign moved  = (d >= 41'sd168) || (d <= -41'sd168);
    assign turned = (r_th >= 58'(TURN_MIN_Q32)) || (r_th <= -58'(TURN_MIN_Q32));

    // config and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpt    <= MPT_RESET;
            r_iwb    <= IWB_RESET;
            r_maxdt  <= MAXDT_RESET;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_pose_x <= '0;
            r_pose_y <= '0;
            r_pose_h <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_METERS_PER_TICK: r_mpt   <= i_cfg_data[23:0];
                    CFG_INV_WHEEL_BASE:  r_iwb   <= i_cfg_data[23:0];
                    CFG_MAX_INTERVAL:    r_maxdt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_prev_l <= i_left_count;
                r_prev_r <= i_right_count;
            end
            if (i_cmd.commit) begin
                if (moved) begin
                    r_pose_x <= sat41(px_sum);
                    r_pose_y <= sat41(py_sum);
                end
                if (turned) r_pose_h <= r_pose_h + r_step;
            end
        end
    end

    // sequencing control of the shared units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_load <= 1'b0;
            r_op   <= OP_NONE;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.start) begin
                r_op   <= i_cmd.op;
                r_load <= 1'b1;
                r_run  <= 1'b0;
            end else if (r_load) begin
                r_load <= 1'b0;
                r_run  <= 1'b1;
                r_cnt  <= '0;
            end else if (last) begin
                r_run <= 1'b0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dl <= 17'(i_left_count) - 17'(r_prev_l);
            r_dr <= 17'(i_right_count) - 17'(r_prev_r);
            r_dt <= i_elapsed_us;
        end
        if (r_load) begin
            case (r_op)
                OP_DIV_V, OP_DIV_W: begin
                    r_neg <= dv_neg;
                    r_nz  <= (r_acc != 64'sd0);
                    r_quo <= dv_mag;
                    r_rem <= '0;
                end
                OP_CORDIC: ;
                default: begin
                    r_ma  <= ld_a;
                    r_mb  <= ld_b;
                    r_acc <= 64'sd0;
                end
            endcase
        end else if (r_run) begin
            case (r_op)
                OP_DIV_V, OP_DIV_W: begin
                    r_rem <= q_rem_nx;
                    r_quo <= q_quo_nx;
                end
                OP_CORDIC: begin
                    if (!r_z[33]) begin
                        r_x <= r_x - c_ys;
                        r_y <= r_y + c_xs;
                        r_z <= r_z - c_atan;
                    end else begin
                        r_x <= r_x + c_ys;
                        r_y <= r_y - c_xs;
                        r_z <= r_z + c_atan;
                    end
                end
                default: begin
                    r_acc <= m_acc_nx;
                    r_ma  <= r_ma <<< 1;
                    r_mb  <= r_mb >> 1;
                end
            endcase
        end
        if (last) begin
            case (r_op)
                OP_MUL_L:    r_wl   <= m_acc_nx[40:0];
                OP_MUL_R:    r_wr   <= m_acc_nx[40:0];
                OP_MUL_TH:   r_th   <= m_acc_nx[57:0];
                OP_MUL_STEP: r_step <= step_round[63:32];
                OP_MUL_GAIN: begin
                    r_x <= fold ? -XW'(x0) : XW'(x0);
                    r_y <= '0;
                    r_z <= 34'(signed'(ang_f));
                end
                OP_DIV_V: r_v <= rate_res(r_neg, r_nz, r_dt == 32'd0, q_quo_nx);
                OP_DIV_W: r_w <= rate_res(r_neg, r_nz, r_dt == 32'd0, q_quo_nx);
                default: ;
            endcase
        end
        if (i_cmd.commit) begin
            r_o_x <= moved ? sat41(px_sum) : r_pose_x;
            r_o_y <= moved ? sat41(py_sum) : r_pose_y;
            r_o_h <= turned ? r_pose_h + r_step : r_pose_h;
            r_o_v <= (r_dt < r_maxdt) ? r_v : 32'd0;
            r_o_w <= (r_dt < r_maxdt) ? r_w : 32'd0;
        end
    end

    assign o_position_x       = r_o_x;
    assign o_position_y       = r_o_y;
    assign o_heading          = r_o_h;
    assign o_linear_velocity  = r_o_v;
    assign o_angular_velocity = r_o_w;

endmodule

FILE: hw/rtl/differential_drive_odometry_core.sv
// Differential-drive wheel odometry. From acceptance to a valid result, each update
// request goes through seven passes of a shared 32-step shift-add multiplier, a
// CORDIC_STEPS-step rotator and two 64-step restoring divisions for the velocities,
// each pass with a load step, then a commit. The next request is taken in the cycle
// after the commit. The first request after reset only latches the encoder counts
// and produces no result. A finished result waits in an output register, so the next
// request can be taken while it is unread; a still unread result stalls the commit.
// Depends on ddo_pkg, ddo_if, ddo_controller and ddo_datapath.
module differential_drive_odometry_core import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ddo_in_if.sink      i_upd,
    ddo_out_if.source   o_pose,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    ddo_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_upd.valid),
        .o_in_ready  (i_upd.ready),
        .i_out_ready (o_pose.ready),
        .o_out_valid (o_pose.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ddo_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_left_count       (i_upd.left_count),
        .i_right_count      (i_upd.right_count),
        .i_elapsed_us       (i_upd.elapsed_us),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_position_x       (o_pose.position_x),
        .o_position_y       (o_pose.position_y),
        .o_heading          (o_pose.heading),
        .o_linear_velocity  (o_pose.linear_velocity),
        .o_angular_velocity (o_pose.angular_velocity)
    );

    // a result never appears in the cycle right after a request is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd.valid && i_upd.ready) |=> !$rose(o_pose.valid))
        else $error("result appeared right after a request");

    // a new result is only committed after the block was busy
    a_commit_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_pose.valid) |-> $past(!i_upd.ready))
        else $error("result committed while idle");

endmodule
